FILE: rtl/rtmm_pkg.sv
package rtmm_pkg;

  // Fixed field widths of the ports.
  localparam int SAMPLE_W    = 12;
  localparam int CFG_W       = 12;
  localparam int VALUE_W     = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;

  // Defaults for the top-level parameters.
  localparam int ADC_BITS_DEF      = 12;
  localparam int GROUP_SAMPLES_DEF = 6;
  localparam int MEDIAN_WINDOW_DEF = 5;

  // Completed groups that may wait between the front and the back end.
  localparam int QUEUE_DEPTH = 2;

  // Register reset values.
  localparam logic [VALUE_W-1:0] Z_THRESHOLD_RST   = 16'd0;
  localparam logic [CFG_W-1:0]   X_RAW_MIN_RST     = 12'd0;
  localparam logic [CFG_W-1:0]   X_RAW_MAX_RST     = 12'd4095;
  localparam logic [CFG_W-1:0]   Y_RAW_MIN_RST     = 12'd0;
  localparam logic [CFG_W-1:0]   Y_RAW_MAX_RST     = 12'd4095;
  localparam logic [CFG_W-1:0]   X_PIXELS_RST      = 12'd320;
  localparam logic [CFG_W-1:0]   Y_PIXELS_RST      = 12'd480;

  typedef enum logic [1:0] {
    MODE_PLATE1 = 2'd0,
    MODE_PLATE2 = 2'd1,
    MODE_X      = 2'd2,
    MODE_Y      = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_PRESSURE = 2'd0,
    KIND_X        = 2'd1,
    KIND_Y        = 2'd2
  } kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_Z_THRESHOLD   = 3'd0,
    CFG_X_RAW_MIN     = 3'd1,
    CFG_X_RAW_MAX     = 3'd2,
    CFG_Y_RAW_MIN     = 3'd3,
    CFG_Y_RAW_MAX     = 3'd4,
    CFG_X_PIXELS      = 3'd5,
    CFG_Y_PIXELS      = 3'd6
  } cfg_index_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_RANK,
    BK_EVAL,
    BK_DIV,
    BK_FIN,
    BK_OUT
  } back_state_t;

  typedef struct packed {
    mode_t               mode;
    logic [SAMPLE_W-1:0] sample;
  } in_word_t;

  typedef struct packed {
    kind_t              kind;
    logic               pressed;
    logic [VALUE_W-1:0] value;
  } out_word_t;

  typedef struct packed {
    logic [VALUE_W-1:0] z_threshold;
    logic [CFG_W-1:0]   x_raw_min;
    logic [CFG_W-1:0]   x_raw_max;
    logic [CFG_W-1:0]   y_raw_min;
    logic [CFG_W-1:0]   y_raw_max;
    logic [CFG_W-1:0]   x_pixels;
    logic [CFG_W-1:0]   y_pixels;
  } cfg_t;

endpackage

FILE: rtl/rtmm_front.sv
module rtmm_front #(
  parameter int ADC_BITS      = rtmm_pkg::ADC_BITS_DEF,
  parameter int GROUP_SAMPLES = rtmm_pkg::GROUP_SAMPLES_DEF,
  parameter int MEDIAN_WINDOW = rtmm_pkg::MEDIAN_WINDOW_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  rtmm_pkg::in_word_t  sample_word,
  input  logic                q_full,
  output logic                q_push,
  output logic [MEDIAN_WINDOW*rtmm_pkg::SAMPLE_W+1:0] q_data
);
  import rtmm_pkg::*;

  localparam int CNT_W = $clog2(GROUP_SAMPLES);
  localparam logic [SAMPLE_W-1:0] SMP_MASK =
    (ADC_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}} : SAMPLE_W'((1 << ADC_BITS) - 1);

  logic [MEDIAN_WINDOW-1:0][SAMPLE_W-1:0] window;
  logic [MEDIAN_WINDOW-1:0][SAMPLE_W-1:0] window_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  cnt_base;
  logic [CNT_W:0]    cnt_inc;
  mode_t             group;
  logic              accept;
  logic              group_done;

  assign sample_stall = q_full;
  assign accept       = sample_valid && !sample_stall;

  // A new group tag restarts the count with this word as its first sample.
  assign cnt_base   = (sample_word.mode != group) ? '0 : count;
  assign cnt_inc    = {1'b0, cnt_base} + (CNT_W+1)'(1);
  assign group_done = (cnt_inc == (CNT_W+1)'(GROUP_SAMPLES));

  always_comb begin
    window_next = window;
    for (int i = 0; i < MEDIAN_WINDOW; i++) begin
      if (cnt_base == CNT_W'(i)) begin
        window_next[i] = sample_word.sample & SMP_MASK;
      end
    end
  end

  assign q_push = accept && group_done;
  assign q_data = {sample_word.mode, window_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      group <= MODE_PLATE1;
    end else if (accept) begin
      group <= sample_word.mode;
      count <= group_done ? '0 : cnt_inc[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      window <= window_next;
    end
  end

endmodule

FILE: rtl/rtmm_queue.sv
module rtmm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rtmm_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);
  import rtmm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DEPTH-1:0][WIDTH-1:0] entries;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full     = (fill == CNT_W'(DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // The front end stalls on a full queue, so no group is ever dropped.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("group pushed into a full queue");

endmodule

FILE: rtl/rtmm_back.sv
module rtmm_back #(
  parameter int ADC_BITS      = rtmm_pkg::ADC_BITS_DEF,
  parameter int MEDIAN_WINDOW = rtmm_pkg::MEDIAN_WINDOW_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  rtmm_pkg::cfg_t      cfg,
  input  logic                q_empty,
  input  logic [MEDIAN_WINDOW*rtmm_pkg::SAMPLE_W+1:0] q_data,
  output logic                q_pop,
  output logic                result_valid,
  input  logic                result_stall,
  output rtmm_pkg::out_word_t result_word
);
  import rtmm_pkg::*;

  localparam int CMP_W  = (ADC_BITS > CFG_W) ? ADC_BITS : CFG_W;
  localparam int PW     = ADC_BITS + CFG_W;
  localparam int STEP_W = $clog2(PW);
  localparam int IDX_W  = $clog2(MEDIAN_WINDOW);
  localparam int RANK_W = $clog2(MEDIAN_WINDOW);
  localparam int MID    = MEDIAN_WINDOW / 2;
  localparam logic [ADC_BITS-1:0] FULL_SCALE = {ADC_BITS{1'b1}};

  back_state_t state;
  back_state_t state_next;

  mode_t                                  job_mode;
  logic [MEDIAN_WINDOW-1:0][SAMPLE_W-1:0] job_win;
  mode_t                                  pop_mode;
  logic [MEDIAN_WINDOW-1:0][SAMPLE_W-1:0] pop_win;
  logic [IDX_W-1:0]    idx;
  logic [SAMPLE_W-1:0] med;
  logic [SAMPLE_W-1:0] p1_med;
  logic                pressed_flag;
  logic [PW-1:0]       dvd;
  logic [CFG_W-1:0]    rem;
  logic [CFG_W-1:0]    dvs;
  logic [STEP_W-1:0]   step;
  kind_t               res_kind;
  logic [VALUE_W-1:0]  res_value;

  // Rank of the candidate entry; ties are broken by position so that exactly
  // one entry holds the middle rank.
  logic [SAMPLE_W-1:0] cand;
  logic [RANK_W-1:0]   rank;

  always_comb begin
    cand = job_win[idx];
    rank = '0;
    for (int j = 0; j < MEDIAN_WINDOW; j++) begin
      if ((job_win[j] < cand) || ((job_win[j] == cand) && (IDX_W'(j) < idx))) begin
        rank = rank + RANK_W'(1);
      end
    end
  end

  // Evaluation of a finished median.
  logic                is_x;
  logic [CFG_W-1:0]    lo;
  logic [CFG_W-1:0]    hi;
  logic [CFG_W-1:0]    size;
  logic [CMP_W-1:0]    raw_ext;
  logic [CMP_W-1:0]    diff;
  logic [PW-1:0]       product;
  logic [VALUE_W:0]    pressure_sum;
  logic [VALUE_W-1:0]  pressure;
  logic                eval_divide;
  logic [VALUE_W-1:0]  eval_value;
  kind_t               eval_kind;

  always_comb begin
    is_x         = (job_mode == MODE_X);
    lo           = is_x ? cfg.x_raw_min : cfg.y_raw_min;
    hi           = is_x ? cfg.x_raw_max : cfg.y_raw_max;
    size         = is_x ? cfg.x_pixels : cfg.y_pixels;
    raw_ext      = CMP_W'(FULL_SCALE) - CMP_W'(med);
    diff         = raw_ext - CMP_W'(lo);
    product      = PW'(diff[ADC_BITS-1:0]) * PW'(size);
    pressure_sum = (VALUE_W+1)'(FULL_SCALE) - (VALUE_W+1)'(p1_med) + (VALUE_W+1)'(med);
    pressure     = pressure_sum[VALUE_W-1:0];
    eval_divide  = 1'b0;
    eval_kind    = is_x ? KIND_X : KIND_Y;
    eval_value   = VALUE_W'(raw_ext);
    if (job_mode == MODE_PLATE2) begin
      eval_kind  = KIND_PRESSURE;
      eval_value = pressure;
    end else if ((lo != '0) && (hi > lo)) begin
      if (raw_ext < CMP_W'(lo)) begin
        eval_value = '0;
      end else begin
        eval_divide = 1'b1;
      end
    end
  end

  // One restoring division step per cycle.
  logic [CFG_W:0] rem_shift;
  logic           div_ge;

  assign rem_shift = {rem, dvd[PW-1]};
  assign div_ge    = (rem_shift >= {1'b0, dvs});

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (!q_empty) state_next = BK_RANK;
      BK_RANK: if (idx == IDX_W'(MEDIAN_WINDOW - 1)) state_next = BK_EVAL;
      BK_EVAL: begin
        if (job_mode == MODE_PLATE1) begin
          state_next = BK_IDLE;
        end else if (eval_divide) begin
          state_next = BK_DIV;
        end else begin
          state_next = BK_OUT;
        end
      end
      BK_DIV:  if (step == STEP_W'(PW - 1)) state_next = BK_FIN;
      BK_FIN:  state_next = BK_OUT;
      BK_OUT:  if (!result_stall) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop                = (state == BK_IDLE) && !q_empty;
    result_valid         = (state == BK_OUT);
    result_word.kind     = res_kind;
    result_word.pressed  = pressed_flag;
    result_word.value    = res_value;
  end

  assign pop_mode = mode_t'(q_data[MEDIAN_WINDOW*SAMPLE_W +: 2]);
  assign pop_win  = q_data[MEDIAN_WINDOW*SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      p1_med       <= '0;
      pressed_flag <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == BK_EVAL) && (job_mode == MODE_PLATE1)) begin
        p1_med <= med;
      end
      if ((state == BK_EVAL) && (job_mode == MODE_PLATE2)) begin
        pressed_flag <= (pressure > cfg.z_threshold);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        job_mode <= pop_mode;
        job_win  <= pop_win;
        idx      <= '0;
      end
      BK_RANK: begin
        if (rank == RANK_W'(MID)) begin
          med <= cand;
        end
        idx <= idx + IDX_W'(1);
      end
      BK_EVAL: begin
        res_kind  <= eval_kind;
        res_value <= eval_value;
        dvd       <= product;
        dvs       <= hi - lo;
        rem       <= '0;
        step      <= '0;
      end
      BK_DIV: begin
        rem  <= div_ge ? CFG_W'(rem_shift - {1'b0, dvs}) : rem_shift[CFG_W-1:0];
        dvd  <= {dvd[PW-2:0], div_ge};
        step <= step + STEP_W'(1);
      end
      BK_FIN: begin
        res_value <= (|dvd[PW-1:VALUE_W]) ? {VALUE_W{1'b1}} : dvd[VALUE_W-1:0];
      end
      BK_OUT: begin
      end
      default: begin
      end
    endcase
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DIV) |-> (dvs != '0))
    else $error("divide started with a zero span");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == BK_FIN) |-> (rem < dvs))
    else $error("division remainder not below the span");

  a_pressed_match: assert property (@(posedge clk) disable iff (rst)
    ((state == BK_OUT) && (res_kind == KIND_PRESSURE))
      |-> (pressed_flag == (res_value > cfg.z_threshold)))
    else $error("pressed flag disagrees with the reported pressure");

endmodule

FILE: rtl/resistive_touch_median_mapper.sv
// Resistive touch filter and mapper. Raw converter words arrive tagged with
// a group (plate one, plate two, X, Y); each group is GROUP_SAMPLES words, of
// which the first MEDIAN_WINDOW are kept and the group value is their median.
// A change of tag restarts collection. Plate one gives no result; plate two
// gives a pressure word and updates the pressed flag; X and Y give
// coordinates, mapped onto the screen when the matching minimum register is
// nonzero and the span is positive. The input takes one word per cycle while
// the group queue (two completed groups deep) has room. Each completed group
// then occupies the back end while it is fetched, its window is ranked, its
// median is evaluated and, for a mapped coordinate, a bit-serial division
// of the ADC_BITS + 12 bit product and a saturation step are done, until
// its result word is taken. Configuration registers may only be written
// while no group is in flight and no result is waiting.
module resistive_touch_median_mapper #(
  parameter int ADC_BITS      = rtmm_pkg::ADC_BITS_DEF,
  parameter int GROUP_SAMPLES = rtmm_pkg::GROUP_SAMPLES_DEF,
  parameter int MEDIAN_WINDOW = rtmm_pkg::MEDIAN_WINDOW_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  rtmm_pkg::in_word_t                   sample_word,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output rtmm_pkg::out_word_t                  result_word,
  input  logic                                 cfg_write,
  input  logic [rtmm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [rtmm_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import rtmm_pkg::*;

  // A queued group carries its tag and a snapshot of the window, so the front
  // end can refill the window while the back end still works on it.
  localparam int JOB_W = MEDIAN_WINDOW * SAMPLE_W + 2;

  cfg_t             cfg;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  logic [JOB_W-1:0] q_in;
  logic [JOB_W-1:0] q_out;

  // Configuration registers. Twelve-bit registers take the low bits of the
  // written word; writes to indexes past the last register are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.z_threshold   <= Z_THRESHOLD_RST;
      cfg.x_raw_min     <= X_RAW_MIN_RST;
      cfg.x_raw_max     <= X_RAW_MAX_RST;
      cfg.y_raw_min     <= Y_RAW_MIN_RST;
      cfg.y_raw_max     <= Y_RAW_MAX_RST;
      cfg.x_pixels      <= X_PIXELS_RST;
      cfg.y_pixels      <= Y_PIXELS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_Z_THRESHOLD:   cfg.z_threshold   <= cfg_data;
        CFG_X_RAW_MIN:     cfg.x_raw_min     <= cfg_data[CFG_W-1:0];
        CFG_X_RAW_MAX:     cfg.x_raw_max     <= cfg_data[CFG_W-1:0];
        CFG_Y_RAW_MIN:     cfg.y_raw_min     <= cfg_data[CFG_W-1:0];
        CFG_Y_RAW_MAX:     cfg.y_raw_max     <= cfg_data[CFG_W-1:0];
        CFG_X_PIXELS:      cfg.x_pixels      <= cfg_data[CFG_W-1:0];
        CFG_Y_PIXELS:      cfg.y_pixels      <= cfg_data[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: collects words into the window and queues finished groups.
  rtmm_front #(
    .ADC_BITS      (ADC_BITS),
    .GROUP_SAMPLES (GROUP_SAMPLES),
    .MEDIAN_WINDOW (MEDIAN_WINDOW)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_word  (sample_word),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_in)
  );

  rtmm_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back end: median by ranking, then pressure or coordinate mapping.
  rtmm_back #(
    .ADC_BITS      (ADC_BITS),
    .MEDIAN_WINDOW (MEDIAN_WINDOW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .q_data       (q_out),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word)
  );

endmodule
